### rtl/tdm_pkg.sv
`default_nettype none

package tdm_pkg;

    // Input word actions
    localparam logic [1:0] ACT_WRITE_TRANS = 2'd0;
    localparam logic [1:0] ACT_WRITE_MARK  = 2'd1;
    localparam logic [1:0] ACT_MATCH       = 2'd2;

    // Configuration register indexes
    localparam logic CFG_INITIAL_STATE = 1'b0;
    localparam logic CFG_SYMBOL_COUNT  = 1'b1;

    // Register reset values
    localparam logic [5:0] INITIAL_STATE_RST = 6'd0;
    localparam logic [5:0] SYMBOL_COUNT_RST  = 6'd26;

    // Symbol 0 is character 'a'
    localparam logic [7:0] CHAR_BASE = 8'd97;

    // Result queue in front of the output port
    localparam int         RESQ_SLOTS = 4;
    localparam int         RESQ_PTR_W = 2;
    localparam logic [2:0] RESQ_LIMIT = 3'd4;

    typedef logic [RESQ_PTR_W-1:0] resq_ptr_t;
    typedef logic [2:0]            resq_cnt_t;

endpackage

`default_nettype wire

### rtl/tdm_ram.sv
`default_nettype none

// Simple dual-port RAM: one write port, one registered read port.
// A read and a write to the same address in one cycle returns the old data.
module tdm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

### rtl/table_driven_dfa_matcher.sv
`default_nettype none

// Channel   Handshake             Word
// -------   -------------------   -------------------------------------------
// in        in_valid / in_ready   action, state_index, symbol_index,
//                                 next_state, accept_mark, char_code, is_last
// out       out_valid / out_ready matched
// cfg       cfg_write             cfg_index, cfg_data
//
// One input word per cycle while in_ready is high. A character looks up the
// transition RAM at the edge it is taken; the RAM output is the state that
// addresses the next lookup. A last character's result goes through the
// final-step stage, the mark-read stage and the result queue before it
// appears at the output. After reset a clearing pass zeroes the mark RAM;
// in_ready stays low meanwhile. in_ready also drops while four results are
// in flight or queued for an output that is stalled.
module table_driven_dfa_matcher #(
    parameter int NUM_STATES  = 64,
    parameter int NUM_SYMBOLS = 32
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    // configuration
    input  wire logic              cfg_write,
    input  wire logic              cfg_index,
    input  wire logic        [5:0] cfg_data,
    // input channel
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic        [1:0] action,
    input  wire logic        [5:0] state_index,
    input  wire logic        [4:0] symbol_index,
    input  wire logic signed [6:0] next_state,
    input  wire logic              accept_mark,
    input  wire logic        [7:0] char_code,
    input  wire logic              is_last,
    // output channel
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic                   matched
);

    localparam int SW = $clog2(NUM_STATES);
    localparam int YW = $clog2(NUM_SYMBOLS);
    localparam int AW = SW + YW;
    localparam int TBL_DEPTH = 1 << AW;
    localparam logic [SW-1:0] LAST_STATE = SW'(NUM_STATES - 1);

    // Configuration registers
    logic [5:0] initial_state_reg, initial_state_next;
    logic [5:0] symbol_count_reg,  symbol_count_next;

    // Running automaton state; loaded with the initial state when a string ends
    logic [SW-1:0] st_reg,    st_next;
    logic          dead_reg,  dead_next;
    logic          look_reg,  look_next;   // state is in the table RAM output

    // Final-step stage
    logic          fin_vld_reg,  fin_vld_next;
    logic          fin_look_reg, fin_look_next;
    logic [SW-1:0] fin_st_reg,   fin_st_next;
    logic          fin_dead_reg, fin_dead_next;

    // Mark-read stage
    logic s2_vld_reg,  s2_vld_next;
    logic s2_dead_reg, s2_dead_next;

    // Mark RAM clearing pass
    logic          clr_busy_reg, clr_busy_next;
    logic [SW-1:0] clr_cnt_reg,  clr_cnt_next;

    // Result queue
    logic [tdm_pkg::RESQ_SLOTS-1:0] resq_mem;
    tdm_pkg::resq_ptr_t    resq_wr_reg, resq_wr_next;
    tdm_pkg::resq_ptr_t    resq_rd_reg, resq_rd_next;
    tdm_pkg::resq_cnt_t    resq_cnt_reg, resq_cnt_next;
    tdm_pkg::resq_cnt_t    credit;

    // RAM ports
    logic          tbl_wr_en, tbl_rd_en;
    logic [AW-1:0] tbl_wr_addr, tbl_rd_addr;
    logic [6:0]    tbl_rd_data;
    logic          mark_wr_en, mark_wr_data, mark_rd_en;
    logic [SW-1:0] mark_wr_addr, mark_rd_addr;
    logic [0:0]    mark_rd_data;

    // Decode and step signals
    logic [31:0]   ent_ext, init_ext, sym_ext, wst_ext, wsym_ext;
    logic          ent_dead, init_dead;
    logic [SW-1:0] ent_state;
    logic [SW-1:0] cur_state;
    logic          cur_dead;
    logic [7:0]    sym_off;
    logic          step_dead;
    logic          accept, is_match, push, pop;
    logic [SW-1:0] fin_state;
    logic          fin_dead;

    tdm_ram #(
        .WIDTH (7),
        .DEPTH (TBL_DEPTH)
    ) u_tbl_ram (
        .clk     (clk),
        .wr_en   (tbl_wr_en),
        .wr_addr (tbl_wr_addr),
        .wr_data (next_state),
        .rd_en   (tbl_rd_en),
        .rd_addr (tbl_rd_addr),
        .rd_data (tbl_rd_data)
    );

    tdm_ram #(
        .WIDTH (1),
        .DEPTH (NUM_STATES)
    ) u_mark_ram (
        .clk     (clk),
        .wr_en   (mark_wr_en),
        .wr_addr (mark_wr_addr),
        .wr_data (mark_wr_data),
        .rd_en   (mark_rd_en),
        .rd_addr (mark_rd_addr),
        .rd_data (mark_rd_data)
    );

    // Handshakes
    assign credit    = tdm_pkg::resq_cnt_t'({2'b00, fin_vld_reg})
                     + tdm_pkg::resq_cnt_t'({2'b00, s2_vld_reg}) + resq_cnt_reg;
    assign in_ready  = !clr_busy_reg && (credit < tdm_pkg::RESQ_LIMIT);
    assign accept    = in_valid && in_ready;
    assign is_match  = (action == tdm_pkg::ACT_MATCH);
    assign out_valid = (resq_cnt_reg != '0);
    assign matched   = resq_mem[resq_rd_reg];
    assign pop       = out_valid && out_ready;
    assign push      = s2_vld_reg;

    // Table entry decode: negative or out-of-range target is dead
    assign ent_ext   = 32'(tbl_rd_data[5:0]);
    assign ent_dead  = tbl_rd_data[6] || (ent_ext >= 32'(NUM_STATES));
    assign ent_state = ent_ext[SW-1:0];

    assign init_ext  = 32'(initial_state_reg);
    assign init_dead = (init_ext >= 32'(NUM_STATES));

    // Current state as seen by the word at the input
    always_comb
    begin
        if (look_reg)
        begin
            cur_state = ent_state;
            cur_dead  = ent_dead;
        end
        else
        begin
            cur_state = st_reg;
            cur_dead  = dead_reg;
        end
    end

    // Symbol checks and lookup address
    assign sym_off   = char_code - tdm_pkg::CHAR_BASE;
    assign sym_ext   = 32'(sym_off);
    assign step_dead = cur_dead || (char_code < tdm_pkg::CHAR_BASE)
                     || (sym_off >= {2'b00, symbol_count_reg})
                     || (sym_ext >= 32'(NUM_SYMBOLS));
    assign tbl_rd_addr = {cur_state, sym_ext[YW-1:0]};
    assign tbl_rd_en   = accept && is_match && !step_dead;

    // Load writes, out-of-range ones dropped
    assign wst_ext     = 32'(state_index);
    assign wsym_ext    = 32'(symbol_index);
    assign tbl_wr_en   = accept && (action == tdm_pkg::ACT_WRITE_TRANS)
                       && (wst_ext < 32'(NUM_STATES)) && (wsym_ext < 32'(NUM_SYMBOLS));
    assign tbl_wr_addr = {wst_ext[SW-1:0], wsym_ext[YW-1:0]};

    // Mark RAM: clearing pass or load write
    always_comb
    begin
        if (clr_busy_reg)
        begin
            mark_wr_en   = 1'b1;
            mark_wr_addr = clr_cnt_reg;
            mark_wr_data = 1'b0;
        end
        else
        begin
            mark_wr_en   = accept && (action == tdm_pkg::ACT_WRITE_MARK)
                         && (wst_ext < 32'(NUM_STATES));
            mark_wr_addr = wst_ext[SW-1:0];
            mark_wr_data = accept_mark;
        end
    end

    // Final state of a finished string, then its mark read
    assign fin_state    = fin_look_reg ? ent_state : fin_st_reg;
    assign fin_dead     = fin_look_reg ? ent_dead  : fin_dead_reg;
    assign mark_rd_en   = fin_vld_reg && !fin_dead;
    assign mark_rd_addr = fin_state;

    // Next-state logic
    always_comb
    begin
        initial_state_next = initial_state_reg;
        symbol_count_next  = symbol_count_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                tdm_pkg::CFG_INITIAL_STATE: initial_state_next = cfg_data;
                tdm_pkg::CFG_SYMBOL_COUNT:  symbol_count_next  = cfg_data;
                default:                    ;
            endcase
        end

        // fold a pending lookup into the state register
        st_next    = look_reg ? ent_state : st_reg;
        dead_next  = look_reg ? ent_dead  : dead_reg;
        look_next  = 1'b0;

        fin_vld_next  = 1'b0;
        fin_look_next = 1'b0;
        fin_st_next   = cur_state;
        fin_dead_next = step_dead;

        if (accept && is_match)
        begin
            if (is_last)
            begin
                // next string starts from the initial state as it is now
                st_next       = init_ext[SW-1:0];
                dead_next     = init_dead;
                fin_vld_next  = 1'b1;
                fin_look_next = !step_dead;
            end
            else
            begin
                st_next    = cur_state;
                dead_next  = step_dead;
                look_next  = !step_dead;
            end
        end

        s2_vld_next  = fin_vld_reg;
        s2_dead_next = fin_dead;

        clr_busy_next = clr_busy_reg;
        clr_cnt_next  = clr_cnt_reg;
        if (clr_busy_reg)
        begin
            clr_cnt_next = clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == LAST_STATE)
            begin
                clr_busy_next = 1'b0;
            end
        end

        resq_wr_next  = push ? resq_wr_reg + 1'b1 : resq_wr_reg;
        resq_rd_next  = pop  ? resq_rd_reg + 1'b1 : resq_rd_reg;
        resq_cnt_next = resq_cnt_reg + tdm_pkg::resq_cnt_t'({2'b00, push})
                      - tdm_pkg::resq_cnt_t'({2'b00, pop});
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            initial_state_reg <= tdm_pkg::INITIAL_STATE_RST;
            symbol_count_reg  <= tdm_pkg::SYMBOL_COUNT_RST;
            st_reg            <= SW'(tdm_pkg::INITIAL_STATE_RST);
            dead_reg          <= 1'b0;
            look_reg          <= 1'b0;
            fin_vld_reg       <= 1'b0;
            fin_look_reg      <= 1'b0;
            s2_vld_reg        <= 1'b0;
            clr_busy_reg      <= 1'b1;
            clr_cnt_reg       <= '0;
            resq_wr_reg       <= '0;
            resq_rd_reg       <= '0;
            resq_cnt_reg      <= '0;
        end
        else
        begin
            initial_state_reg <= initial_state_next;
            symbol_count_reg  <= symbol_count_next;
            st_reg            <= st_next;
            dead_reg          <= dead_next;
            look_reg          <= look_next;
            fin_vld_reg       <= fin_vld_next;
            fin_look_reg      <= fin_look_next;
            s2_vld_reg        <= s2_vld_next;
            clr_busy_reg      <= clr_busy_next;
            clr_cnt_reg       <= clr_cnt_next;
            resq_wr_reg       <= resq_wr_next;
            resq_rd_reg       <= resq_rd_next;
            resq_cnt_reg      <= resq_cnt_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        fin_st_reg   <= fin_st_next;
        fin_dead_reg <= fin_dead_next;
        s2_dead_reg  <= s2_dead_next;
        if (push)
        begin
            resq_mem[resq_wr_reg] <= !s2_dead_reg && mark_rd_data[0];
        end
    end

endmodule

`default_nettype wire
